>>> hdl/dto_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dto_pkg
// Shared types, codes and control store for the depth-first topological sorter
// ----------------------------------------------------------------------------
package dto_pkg;

    localparam int VERTICES_DEF   = 16;
    localparam int MAX_DEGREE_DEF = 8;

    localparam int OP_W     = 2;
    localparam int VID_W    = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [CFG_W-1:0]       VCOUNT_RESET     = 5'd16;
    localparam logic [PADDR_W-3:0]     REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_SORT  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ORDER  = 2'd0,
        ST_OK     = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        A_NONE,
        A_LATCH,
        A_ADD,
        A_CLR,
        A_SORT_INIT,
        A_PROBE_V,
        A_START,
        A_NB_RD,
        A_PUSH,
        A_POP,
        A_RESTORE,
        A_V_INC,
        A_EMIT_INIT,
        A_FIN_RD,
        A_EMIT
    } act_t;

    typedef enum logic [2:0] {
        C_IN_VALID,
        C_OUT_FREE,
        C_V_DONE,
        C_SKIP,
        C_POS_DONE,
        C_STACK_MORE,
        C_IDX_ZERO
    } cond_t;

    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_GOTO,
        SQ_BR,
        SQ_WAIT,
        SQ_DISP
    } seq_t;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_FETCH     = 5'd0;
    localparam step_t S_DISPATCH  = 5'd1;
    localparam step_t S_ADD       = 5'd2;
    localparam step_t S_CLR       = 5'd3;
    localparam step_t S_SORT      = 5'd4;
    localparam step_t S_OUTER     = 5'd5;
    localparam step_t S_OUTER_CHK = 5'd6;
    localparam step_t S_START     = 5'd7;
    localparam step_t S_LOOP      = 5'd8;
    localparam step_t S_NB_CHK    = 5'd9;
    localparam step_t S_PUSH      = 5'd10;
    localparam step_t S_POP       = 5'd11;
    localparam step_t S_OUTER_INC = 5'd12;
    localparam step_t S_RESTORE   = 5'd13;
    localparam step_t S_EMIT_INIT = 5'd14;
    localparam step_t S_EMIT_RD   = 5'd15;
    localparam step_t S_EMIT      = 5'd16;
    localparam step_t S_LAST      = S_EMIT;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        seq_t  seq;
        step_t target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic out_free;
        logic v_done;
        logic skip;
        logic pos_done;
        logic stack_more;
        logic idx_zero;
    } flags_t;

    function automatic uword_t ucode_rom(input step_t addr);
        uword_t w;
        w = '{act: A_NONE, cond: C_IN_VALID, seq: SQ_GOTO, target: S_FETCH};
        unique case (addr)
            S_FETCH:     w = '{A_LATCH,     C_IN_VALID,   SQ_WAIT, S_DISPATCH};
            S_DISPATCH:  w = '{A_NONE,      C_IN_VALID,   SQ_DISP, S_FETCH};
            S_ADD:       w = '{A_ADD,       C_OUT_FREE,   SQ_WAIT, S_FETCH};
            S_CLR:       w = '{A_CLR,       C_OUT_FREE,   SQ_WAIT, S_FETCH};
            S_SORT:      w = '{A_SORT_INIT, C_IN_VALID,   SQ_NEXT, S_FETCH};
            S_OUTER:     w = '{A_PROBE_V,   C_V_DONE,     SQ_BR,   S_EMIT_INIT};
            S_OUTER_CHK: w = '{A_NONE,      C_SKIP,       SQ_BR,   S_OUTER_INC};
            S_START:     w = '{A_START,     C_IN_VALID,   SQ_NEXT, S_FETCH};
            S_LOOP:      w = '{A_NB_RD,     C_POS_DONE,   SQ_BR,   S_POP};
            S_NB_CHK:    w = '{A_NONE,      C_SKIP,       SQ_BR,   S_LOOP};
            S_PUSH:      w = '{A_PUSH,      C_IN_VALID,   SQ_GOTO, S_LOOP};
            S_POP:       w = '{A_POP,       C_STACK_MORE, SQ_BR,   S_RESTORE};
            S_OUTER_INC: w = '{A_V_INC,     C_IN_VALID,   SQ_GOTO, S_OUTER};
            S_RESTORE:   w = '{A_RESTORE,   C_IN_VALID,   SQ_GOTO, S_LOOP};
            S_EMIT_INIT: w = '{A_EMIT_INIT, C_IN_VALID,   SQ_NEXT, S_FETCH};
            S_EMIT_RD:   w = '{A_FIN_RD,    C_IDX_ZERO,   SQ_BR,   S_FETCH};
            S_EMIT:      w = '{A_EMIT,      C_OUT_FREE,   SQ_WAIT, S_EMIT_RD};
            default:     w = '{A_NONE,      C_IN_VALID,   SQ_GOTO, S_FETCH};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> hdl/dfs_topological_order.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_topological_order
// Depth-first topological sorter with per-vertex neighbour lists and an APB
// register for the number of vertices in use
// ----------------------------------------------------------------------------
// add edge / clear: result loaded after dispatch, once the output is free
// sort: depth-first walk from each unvisited vertex, then the finish list
//   sent in reverse, one control word per cycle from the sequencer store
// one input beat at a time; the next is taken once the last result is loaded
// synchronous active-low reset: empty lists, vertex_count 16, no clearing pass
// ----------------------------------------------------------------------------
module dfs_topological_order
    import dto_pkg::*;
#(
    parameter int VERTICES   = VERTICES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire [OP_W-1:0]      s_operation,
    input  wire [VID_W-1:0]     s_from_vertex,
    input  wire [VID_W-1:0]     s_to_vertex,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [VID_W-1:0]    m_vertex,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [PADDR_W-1:0]   paddr,
    input  wire [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [CFG_W-1:0] vcount_reg;
    logic             reg_hit;
    flags_t           flags;
    act_t             act;

    assign reg_hit = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DATA_W'(vcount_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            vcount_reg <= pwdata[CFG_W-1:0];
        end
    end

    dto_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .flags    (flags),
        .act      (act),
        .in_ready (s_ready)
    );

    dto_datapath #(
        .VERTICES   (VERTICES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .act           (act),
        .s_operation   (s_operation),
        .s_from_vertex (s_from_vertex),
        .s_to_vertex   (s_to_vertex),
        .vertex_count  (vcount_reg),
        .flags         (flags),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_vertex      (m_vertex),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

>>> hdl/dto_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dto_seq
// Step counter and control store: fetches one control word per cycle, picks
// the next step and issues the datapath action
// ----------------------------------------------------------------------------
module dto_seq
    import dto_pkg::*;
(
    input  wire    aclk,
    input  wire    aresetn,
    input  wire    in_valid,
    input  flags_t flags,
    output act_t   act,
    output logic   in_ready
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   cond_true;

    assign uw       = ucode_rom(step_reg);
    assign in_ready = (step_reg == S_FETCH);

    always_comb begin
        unique case (uw.cond)
            C_IN_VALID:   cond_true = in_valid;
            C_OUT_FREE:   cond_true = flags.out_free;
            C_V_DONE:     cond_true = flags.v_done;
            C_SKIP:       cond_true = flags.skip;
            C_POS_DONE:   cond_true = flags.pos_done;
            C_STACK_MORE: cond_true = flags.stack_more;
            C_IDX_ZERO:   cond_true = flags.idx_zero;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        act       = A_NONE;
        unique case (uw.seq)
            SQ_NEXT: begin
                step_next = step_reg + STEP_W'(1);
                act       = uw.act;
            end
            SQ_GOTO: begin
                step_next = uw.target;
                act       = uw.act;
            end
            SQ_BR: begin
                step_next = cond_true ? uw.target : step_reg + STEP_W'(1);
                act       = uw.act;
            end
            SQ_WAIT: begin
                if (cond_true) begin
                    step_next = uw.target;
                    act       = uw.act;
                end
            end
            SQ_DISP: begin
                act = uw.act;
                unique case (flags.op)
                    OP_ADD:   step_next = S_ADD;
                    OP_SORT:  step_next = S_SORT;
                    OP_CLEAR: step_next = S_CLR;
                    OP_NONE:  step_next = S_FETCH;
                endcase
            end
            default: step_next = S_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= S_LAST)
        else $error("step counter left the program");

    a_fetch_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ready && in_valid) |=> step_reg == S_DISPATCH)
        else $error("accepted beat not dispatched");

endmodule
`default_nettype wire

>>> hdl/dto_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dto_datapath
// Neighbour lists, walk stack, finish list, visited marks and result register,
// driven one action per cycle by the sequencer, none while it waits
// ----------------------------------------------------------------------------
module dto_datapath
    import dto_pkg::*;
#(
    parameter int VERTICES   = VERTICES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  act_t                act,
    input  wire [OP_W-1:0]      s_operation,
    input  wire [VID_W-1:0]     s_from_vertex,
    input  wire [VID_W-1:0]     s_to_vertex,
    input  wire [CFG_W-1:0]     vertex_count,
    output flags_t              flags,
    input  wire                 m_ready,
    output logic                m_valid,
    output logic [VID_W-1:0]    m_vertex,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last
);

    localparam int VW     = $clog2(VERTICES);
    localparam int CW     = $clog2(VERTICES + 1);
    localparam int CMPW   = (CW > CFG_W) ? CW : CFG_W;
    localparam int DGW    = $clog2(MAX_DEGREE + 1);
    localparam int NDEPTH = VERTICES * MAX_DEGREE;
    localparam int AW     = $clog2(NDEPTH);

    // memories
    logic [VW-1:0]  nb_mem    [NDEPTH];
    logic [VW-1:0]  stk_v_mem [VERTICES];
    logic [DGW-1:0] stk_p_mem [VERTICES];
    logic [VW-1:0]  fin_mem   [VERTICES];

    // control state
    logic [DGW-1:0]  deg_reg [VERTICES];
    logic [VERTICES-1:0] visited_reg;
    logic [CMPW-1:0] v_reg;
    logic [VW-1:0]   top_reg;
    logic [DGW-1:0]  pos_reg;
    logic [CW-1:0]   depth_reg;
    logic [CW-1:0]   fin_cnt_reg;
    logic [CW-1:0]   idx_reg;
    logic            m_valid_reg;

    // payload
    op_t             op_reg;
    logic [VID_W-1:0] from_reg;
    logic [VID_W-1:0] to_reg;
    logic [VW-1:0]   probe_reg;
    logic [VW-1:0]   stk_v_q;
    logic [DGW-1:0]  stk_p_q;
    logic [VW-1:0]   fin_q;
    logic [VID_W-1:0] m_vertex_reg;
    status_t         m_status_reg;
    logic            m_last_reg;

    logic [CMPW-1:0] cfg_ext;
    logic [CMPW-1:0] count;
    logic [VW-1:0]   from_idx;
    logic [DGW-1:0]  deg_from;
    logic [DGW-1:0]  deg_top;
    logic            add_ok;
    logic [AW-1:0]   nb_wr_addr;
    logic [AW-1:0]   nb_rd_addr;
    logic [CW-1:0]   stk_wr_cnt;
    logic [CW-1:0]   stk_rd_cnt;
    logic [CW-1:0]   fin_rd_cnt;
    logic            out_free;
    logic            res_load;

    // vertices in use, clamped to the built size; zero counts as one
    assign cfg_ext = CMPW'(vertex_count);
    always_comb begin
        priority if (cfg_ext == '0) begin
            count = CMPW'(1);
        end else if (cfg_ext > CMPW'(VERTICES)) begin
            count = CMPW'(VERTICES);
        end else begin
            count = cfg_ext;
        end
    end

    assign from_idx   = VW'(from_reg);
    assign deg_from   = deg_reg[from_idx];
    assign deg_top    = deg_reg[top_reg];
    assign add_ok     = (CMPW'(from_reg) < count) && (CMPW'(to_reg) < count)
                        && (deg_from < DGW'(MAX_DEGREE));
    assign nb_wr_addr = AW'(from_idx * MAX_DEGREE) + AW'(deg_from);
    assign nb_rd_addr = AW'(top_reg * MAX_DEGREE) + AW'(pos_reg);
    assign stk_wr_cnt = depth_reg - CW'(1);
    assign stk_rd_cnt = depth_reg - CW'(2);
    assign fin_rd_cnt = idx_reg - CW'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign res_load   = (act == A_ADD) || (act == A_CLR) || (act == A_EMIT);

    assign flags.op         = op_reg;
    assign flags.out_free   = out_free;
    assign flags.v_done     = (v_reg >= count);
    assign flags.skip       = (CMPW'(probe_reg) >= count) || visited_reg[probe_reg];
    assign flags.pos_done   = (pos_reg >= deg_top);
    assign flags.stack_more = (depth_reg > CW'(1));
    assign flags.idx_zero   = (idx_reg == '0);

    assign m_valid  = m_valid_reg;
    assign m_vertex = m_vertex_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VERTICES; i++) begin
                deg_reg[i] <= '0;
            end
            visited_reg <= '0;
            v_reg       <= '0;
            top_reg     <= '0;
            pos_reg     <= '0;
            depth_reg   <= '0;
            fin_cnt_reg <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (act)
                A_ADD: begin
                    if (add_ok) begin
                        deg_reg[from_idx] <= deg_from + DGW'(1);
                    end
                end
                A_CLR: begin
                    for (int i = 0; i < VERTICES; i++) begin
                        deg_reg[i] <= '0;
                    end
                end
                A_SORT_INIT: begin
                    visited_reg <= '0;
                    fin_cnt_reg <= '0;
                    v_reg       <= '0;
                end
                A_START: begin
                    visited_reg[probe_reg] <= 1'b1;
                    top_reg   <= probe_reg;
                    pos_reg   <= '0;
                    depth_reg <= CW'(1);
                end
                A_NB_RD: begin
                    pos_reg <= pos_reg + DGW'(1);
                end
                A_PUSH: begin
                    visited_reg[probe_reg] <= 1'b1;
                    top_reg   <= probe_reg;
                    pos_reg   <= '0;
                    depth_reg <= depth_reg + CW'(1);
                end
                A_POP: begin
                    fin_cnt_reg <= fin_cnt_reg + CW'(1);
                    depth_reg   <= depth_reg - CW'(1);
                end
                A_RESTORE: begin
                    top_reg <= stk_v_q;
                    pos_reg <= stk_p_q;
                end
                A_V_INC: begin
                    v_reg <= v_reg + CMPW'(1);
                end
                A_EMIT_INIT: begin
                    idx_reg <= fin_cnt_reg;
                end
                A_EMIT: begin
                    idx_reg <= idx_reg - CW'(1);
                end
                default: ;
            endcase
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (act)
            A_LATCH: begin
                op_reg   <= op_t'(s_operation);
                from_reg <= s_from_vertex;
                to_reg   <= s_to_vertex;
            end
            A_ADD: begin
                if (add_ok) begin
                    nb_mem[nb_wr_addr] <= VW'(to_reg);
                end
                m_vertex_reg <= '0;
                m_status_reg <= add_ok ? ST_OK : ST_REJECT;
                m_last_reg   <= 1'b1;
            end
            A_CLR: begin
                m_vertex_reg <= '0;
                m_status_reg <= ST_OK;
                m_last_reg   <= 1'b1;
            end
            A_PROBE_V: begin
                probe_reg <= v_reg[VW-1:0];
            end
            A_NB_RD: begin
                probe_reg <= nb_mem[nb_rd_addr];
            end
            A_PUSH: begin
                stk_v_mem[stk_wr_cnt[VW-1:0]] <= top_reg;
                stk_p_mem[stk_wr_cnt[VW-1:0]] <= pos_reg;
            end
            A_POP: begin
                fin_mem[fin_cnt_reg[VW-1:0]] <= top_reg;
                stk_v_q <= stk_v_mem[stk_rd_cnt[VW-1:0]];
                stk_p_q <= stk_p_mem[stk_rd_cnt[VW-1:0]];
            end
            A_FIN_RD: begin
                fin_q <= fin_mem[fin_rd_cnt[VW-1:0]];
            end
            A_EMIT: begin
                m_vertex_reg <= VID_W'(fin_q);
                m_status_reg <= ST_ORDER;
                m_last_reg   <= (idx_reg == CW'(1));
            end
            default: ;
        endcase
    end

    a_push_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (act == A_PUSH) |=> depth_reg == $past(depth_reg) + CW'(1))
        else $error("push did not deepen the stack");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (act == A_LATCH) |-> depth_reg == '0)
        else $error("walk stack not empty between beats");

    a_all_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (act == A_EMIT_INIT) |-> CMPW'(fin_cnt_reg) == count)
        else $error("finish list does not cover every vertex");

endmodule
`default_nettype wire
